// ===== hw/rtl/sgs_pkg.sv =====
// ----------------------------------------------------------------------------
// sgs_pkg
// Shared types and constants of the Sobel gradient stream: field widths,
// register indexes, the window job handed from front to back, and states.
// ----------------------------------------------------------------------------
package sgs_pkg;

   // Field widths
   localparam int SGS_PIXEL_W    = 8;
   localparam int SGS_COORD_W    = 10;
   localparam int SGS_DIM_W      = 11;
   localparam int SGS_GRAD_W     = 9;
   localparam int SGS_MAG_W      = 8;
   localparam int SGS_SQ_W       = 17;
   localparam int SGS_REQ_DATA_W = 8;
   localparam int SGS_RSP_DATA_W = 48;

   // Frame size limits and reset values
   localparam int                   SGS_DIM_MAX      = 1024;
   localparam logic [SGS_DIM_W-1:0] SGS_DIM_MIN      = 11'd2;
   localparam logic [SGS_DIM_W-1:0] SGS_WIDTH_RESET  = 11'd640;
   localparam logic [SGS_DIM_W-1:0] SGS_HEIGHT_RESET = 11'd480;

   // Register indexes
   localparam int                        SGS_CSR_INDEX_W      = 2;
   localparam logic [SGS_CSR_INDEX_W-1:0] SGS_CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [SGS_CSR_INDEX_W-1:0] SGS_CSR_FRAME_HEIGHT = 2'd1;

   // Depth of the job queue between front and back
   localparam int SGS_QUEUE_DEPTH = 4;

   // One window position: 3x3 neighborhood (row-major, top row first)
   // plus the position of the pixel that completed it.
   typedef struct packed {
      logic [8:0][SGS_PIXEL_W-1:0] win;
      logic [SGS_COORD_W-1:0]      row;
      logic [SGS_COORD_W-1:0]      col;
      logic                        last_col;
      logic                        last_row;
      logic                        left_rep;
   } sgs_job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } sgs_queue_status_type;

   // Result variant within one job: centre, right border, bottom border, corner
   typedef enum logic [1:0] {
      VAR_CENTER = 2'd0,
      VAR_RIGHT  = 2'd1,
      VAR_LOWER  = 2'd2,
      VAR_CORNER = 2'd3
   } sgs_variant_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_GRAD,
      BK_SQUARE,
      BK_ROOT
   } sgs_back_state_type;

endpackage

// ===== hw/rtl/sobel_gradient_stream.sv =====
// ----------------------------------------------------------------------------
// sobel_gradient_stream
// Streaming 3x3 Sobel gradient and magnitude over a configurable frame.
// ----------------------------------------------------------------------------
// Grey pixels enter in raster order on req_; each result word on rsp_ carries
// gx/4 and gy/4 (truncated toward zero, -255..255), the floor root of
// gx^2+gy^2 saturated to 255, and the row and column of its centre pixel;
// rsp_tlast marks the bottom-right result of a frame. Borders are replicated.
// A result leaves once its lower-right neighbor has arrived; pixels of row 0
// and column 0 give none, a last-column pixel adds the right-border result,
// and last-row pixels add the bottom-row results after those of the row
// above. A pixel is taken whenever the window stage is free, so bursts run
// at one pixel per clock until the four-entry job queue fills. Each result
// then passes through the back end in turn (gradient, square, eight steps
// of the bit-serial root unit, output load), and the first result of a job
// also waits for the job to be taken from the queue; a result whose sum of
// squares saturates the root skips the root steps. The output load waits
// while rsp_tready is low and the output word is held, and the root unit
// sets the sustained rate. Writing either frame register restarts the frame
// at row 0, column 0; the line buffers need no clearing after reset.
// ----------------------------------------------------------------------------
module sobel_gradient_stream #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: [7:0] pixel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [sgs_pkg::SGS_REQ_DATA_W-1:0]   req_tdata,
   // rsp_tdata: [8:0] grad_x, [17:9] grad_y, [25:18] magnitude,
   //            [35:26] out_row, [45:36] out_col, [47:46] zero
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [sgs_pkg::SGS_RSP_DATA_W-1:0]   rsp_tdata,
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sgs_pkg::SGS_CSR_INDEX_W-1:0]  csr_index,
   input  logic [sgs_pkg::SGS_DIM_W-1:0]        csr_data
);
   import sgs_pkg::*;

   logic                 push, pop;
   sgs_job_type          push_data, pop_data;
   sgs_queue_status_type queue_status;

   sgs_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .job_push     (push),
      .job_data     (push_data),
      .queue_status (queue_status)
   );

   sgs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (queue_status)
   );

   sgs_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .job_data     (pop_data),
      .job_pop      (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

endmodule

// ===== hw/rtl/sgs_sqrt.sv =====
// ----------------------------------------------------------------------------
// sgs_sqrt
// Iterative floor square root, one result bit per cycle, saturated to 255.
// ----------------------------------------------------------------------------
module sgs_sqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [sgs_pkg::SGS_SQ_W-1:0]    operand,
   output logic                            busy,
   output logic [sgs_pkg::SGS_MAG_W-1:0]   root
);
   import sgs_pkg::*;

   localparam int BIT_W = $clog2(SGS_MAG_W);

   logic                  busy_ff, busy_in;
   logic [SGS_MAG_W-1:0]  root_ff, root_in;
   logic [2*SGS_MAG_W-1:0] op_ff, op_in;
   logic [BIT_W-1:0]      bit_ff, bit_in;
   logic [SGS_MAG_W-1:0]  trial;
   logic [2*SGS_MAG_W-1:0] trial_sq;
   logic [2*SGS_MAG_W-1:0] root_sq;
   logic [SGS_MAG_W:0]    root_inc;
   logic [2*SGS_MAG_W+1:0] inc_sq;

   // Try the next lower bit of the root
   assign trial    = root_ff | (SGS_MAG_W'(1) << bit_ff);
   assign trial_sq = trial * trial;

   always_comb begin
      busy_in = busy_ff;
      root_in = root_ff;
      op_in   = op_ff;
      bit_in  = bit_ff;
      if (start) begin
         if (operand[SGS_SQ_W-1]) begin
            // Root is at least 256: saturate at once
            root_in = '1;
            busy_in = 1'b0;
         end else begin
            root_in = '0;
            op_in   = operand[2*SGS_MAG_W-1:0];
            bit_in  = BIT_W'(SGS_MAG_W - 1);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (trial_sq <= op_ff) begin
            root_in = trial;
         end
         if (bit_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            bit_in = bit_ff - BIT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      root_ff <= root_in;
      op_ff   <= op_in;
      bit_ff  <= bit_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;

   // Result check terms
   assign root_sq  = root_ff * root_ff;
   assign root_inc = {1'b0, root_ff} + (SGS_MAG_W+1)'(1);
   assign inc_sq   = root_inc * root_inc;

   a_root_floor : assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> (root_sq <= op_ff) && (inc_sq > {2'b00, op_ff}))
      else $error("square root result is not the floor root");

endmodule

// ===== hw/rtl/sgs_queue.sv =====
// ----------------------------------------------------------------------------
// sgs_queue
// Short first-in first-out queue of window jobs between front and back.
// ----------------------------------------------------------------------------
module sgs_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  sgs_pkg::sgs_job_type          push_data,
   input  logic                          pop,
   output sgs_pkg::sgs_job_type          pop_data,
   output sgs_pkg::sgs_queue_status_type status
);
   import sgs_pkg::*;

   localparam int PTR_W = $clog2(SGS_QUEUE_DEPTH);
   localparam int CNT_W = $clog2(SGS_QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(SGS_QUEUE_DEPTH - 1);

   sgs_job_type      entry_ff [SGS_QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(SGS_QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   a_no_push_full : assert property (@(posedge clock) disable iff (reset)
      !(push && status.full))
      else $error("job pushed into a full queue");

   a_no_pop_empty : assert property (@(posedge clock) disable iff (reset)
      !(pop && status.empty))
      else $error("job popped from an empty queue");

endmodule

// ===== hw/rtl/sgs_front.sv =====
// ----------------------------------------------------------------------------
// sgs_front
// Pixel intake: frame registers, raster counters, two line buffers and the
// 3x3 window. Each pixel that completes a window pushes one job.
// ----------------------------------------------------------------------------
module sgs_front #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [sgs_pkg::SGS_REQ_DATA_W-1:0]     req_tdata,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [sgs_pkg::SGS_CSR_INDEX_W-1:0]    csr_index,
   input  logic [sgs_pkg::SGS_DIM_W-1:0]          csr_data,
   output logic                                   job_push,
   output sgs_pkg::sgs_job_type                   job_data,
   input  sgs_pkg::sgs_queue_status_type          queue_status
);
   import sgs_pkg::*;

   localparam int ADDR_W      = $clog2(MAX_WIDTH);
   localparam int WIDTH_LIMIT = (MAX_WIDTH < SGS_DIM_MAX) ? MAX_WIDTH : SGS_DIM_MAX;
   localparam logic [SGS_DIM_W-1:0] WIDTH_MAX  = SGS_DIM_W'(WIDTH_LIMIT);
   localparam logic [SGS_DIM_W-1:0] HEIGHT_MAX = SGS_DIM_W'(SGS_DIM_MAX);

   logic [SGS_DIM_W-1:0]   frame_width_ff, frame_width_in;
   logic [SGS_DIM_W-1:0]   frame_height_ff, frame_height_in;
   logic [SGS_DIM_W-1:0]   width_eff, height_eff, width_last, height_last;
   logic [SGS_COORD_W-1:0] col_ff, col_in, row_ff, row_in;
   logic                   at_last_col, at_last_row;
   logic                   cfg_write, accept;

   logic                   a_valid_ff, a_valid_in;
   logic [SGS_PIXEL_W-1:0] a_pixel_ff;
   logic [SGS_COORD_W-1:0] a_col_ff, a_row_ff;
   logic                   a_last_col_ff, a_last_row_ff;

   logic [SGS_PIXEL_W-1:0] line_above_mem [MAX_WIDTH];
   logic [SGS_PIXEL_W-1:0] line_two_mem [MAX_WIDTH];
   logic [SGS_PIXEL_W-1:0] above_rd_ff, two_rd_ff;
   logic [ADDR_W-1:0]      rd_addr, wr_addr;

   logic [8:0][SGS_PIXEL_W-1:0] window_ff, window_in;
   logic [SGS_PIXEL_W-1:0] top_px, mid_px;
   logic                   has_result, b_advance;

   // Configuration writes are always taken
   assign csr_ready = 1'b1;
   assign cfg_write = csr_valid && csr_ready;

   // Clamp frame size to the supported range
   always_comb begin
      if (frame_width_ff < SGS_DIM_MIN) begin
         width_eff = SGS_DIM_MIN;
      end else if (frame_width_ff > WIDTH_MAX) begin
         width_eff = WIDTH_MAX;
      end else begin
         width_eff = frame_width_ff;
      end
      if (frame_height_ff < SGS_DIM_MIN) begin
         height_eff = SGS_DIM_MIN;
      end else if (frame_height_ff > HEIGHT_MAX) begin
         height_eff = HEIGHT_MAX;
      end else begin
         height_eff = frame_height_ff;
      end
   end

   assign width_last  = width_eff - SGS_DIM_W'(1);
   assign height_last = height_eff - SGS_DIM_W'(1);
   assign at_last_col = ({1'b0, col_ff} == width_last);
   assign at_last_row = ({1'b0, row_ff} == height_last);

   // Window stage: finish the held pixel unless its job cannot be queued
   assign has_result = a_valid_ff && (a_row_ff != '0) && (a_col_ff != '0);
   assign b_advance  = a_valid_ff && (!has_result || !queue_status.full);
   assign req_tready = !a_valid_ff || b_advance;
   assign accept     = req_tvalid && req_tready;

   // Register writes and raster position
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      if (cfg_write && (csr_index == SGS_CSR_FRAME_WIDTH)) begin
         frame_width_in = csr_data;
         col_in         = '0;
         row_in         = '0;
      end else if (cfg_write && (csr_index == SGS_CSR_FRAME_HEIGHT)) begin
         frame_height_in = csr_data;
         col_in          = '0;
         row_in          = '0;
      end else if (accept) begin
         if (at_last_col) begin
            col_in = '0;
            row_in = at_last_row ? '0 : row_ff + SGS_COORD_W'(1);
         end else begin
            col_in = col_ff + SGS_COORD_W'(1);
         end
      end
   end

   always_comb begin
      a_valid_in = a_valid_ff;
      if (accept) begin
         a_valid_in = 1'b1;
      end else if (b_advance) begin
         a_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= SGS_WIDTH_RESET;
         frame_height_ff <= SGS_HEIGHT_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
         a_valid_ff      <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         a_valid_ff      <= a_valid_in;
      end
   end

   // Hold the accepted pixel and its position
   always_ff @(posedge clock) begin
      if (accept) begin
         a_pixel_ff    <= req_tdata[SGS_PIXEL_W-1:0];
         a_col_ff      <= col_ff;
         a_row_ff      <= row_ff;
         a_last_col_ff <= at_last_col;
         a_last_row_ff <= at_last_row;
      end
   end

   // Line buffers: read on accept, write back when the window stage finishes
   assign rd_addr = ADDR_W'(col_ff);
   assign wr_addr = ADDR_W'(a_col_ff);

   always_ff @(posedge clock) begin
      if (accept) begin
         above_rd_ff <= line_above_mem[rd_addr];
         two_rd_ff   <= line_two_mem[rd_addr];
      end
      if (b_advance) begin
         line_two_mem[wr_addr]   <= above_rd_ff;
         line_above_mem[wr_addr] <= a_pixel_ff;
      end
   end

   // Replicate the top border on the first two rows
   always_comb begin
      if (a_row_ff == '0) begin
         mid_px = a_pixel_ff;
         top_px = a_pixel_ff;
      end else begin
         mid_px = above_rd_ff;
         top_px = (a_row_ff == SGS_COORD_W'(1)) ? above_rd_ff : two_rd_ff;
      end
   end

   // Shift the window left and load the new column
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         window_in[i*3]     = window_ff[i*3 + 1];
         window_in[i*3 + 1] = window_ff[i*3 + 2];
      end
      window_in[2] = top_px;
      window_in[5] = mid_px;
      window_in[8] = a_pixel_ff;
   end

   always_ff @(posedge clock) begin
      if (b_advance) begin
         window_ff <= window_in;
      end
   end

   assign job_push          = b_advance && has_result;
   assign job_data.win      = window_in;
   assign job_data.row      = a_row_ff;
   assign job_data.col      = a_col_ff;
   assign job_data.last_col = a_last_col_ff;
   assign job_data.last_row = a_last_row_ff;
   assign job_data.left_rep = (a_col_ff == SGS_COORD_W'(1));

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && !b_advance |=>
         a_valid_ff && $stable(a_pixel_ff) && $stable(above_rd_ff) && $stable(two_rd_ff))
      else $error("stalled window stage lost its pixel or line data");

endmodule

// ===== hw/rtl/sgs_back.sv =====
// ----------------------------------------------------------------------------
// sgs_back
// Result sequencer: takes window jobs, emits one to four gradient results
// per job through the shared root unit, into the output register.
// ----------------------------------------------------------------------------
module sgs_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sgs_pkg::sgs_queue_status_type        queue_status,
   input  sgs_pkg::sgs_job_type                 job_data,
   output logic                                 job_pop,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [sgs_pkg::SGS_RSP_DATA_W-1:0]   rsp_tdata,
   output logic                                 rsp_tlast
);
   import sgs_pkg::*;

   localparam int SUM_W = SGS_PIXEL_W + 2;
   localparam int SX_W  = SUM_W + 2;
   localparam int PAD_W = SGS_RSP_DATA_W - 2*SGS_GRAD_W - SGS_MAG_W - 2*SGS_COORD_W;

   sgs_back_state_type state_ff, state_in;
   sgs_job_type        job_ff;
   sgs_variant_type    kind_ff, kind_in, next_kind;
   logic               has_more;

   logic signed [SGS_GRAD_W-1:0] gx_ff, gy_ff, gx_in, gy_in;
   logic signed [2*SGS_GRAD_W-1:0] gx_sq, gy_sq;

   logic                  sqrt_start, sqrt_busy;
   logic [SGS_SQ_W-1:0]   sqrt_operand;
   logic [SGS_MAG_W-1:0]  sqrt_root;

   logic                  out_free, load_out;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SGS_RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_last_ff;

   logic                  lower, right;
   logic [2:0][1:0]       rsel, csel;
   logic [SGS_PIXEL_W-1:0] p [9];
   logic [SUM_W-1:0]      sum_xl, sum_xr, sum_yt, sum_yb;
   logic signed [SX_W-1:0] sx, sy, sx_adj, sy_adj, sx_q, sy_q;
   logic [SGS_COORD_W-1:0] out_row, out_col;

   function automatic logic [SGS_PIXEL_W-1:0] pick(
      input logic [8:0][SGS_PIXEL_W-1:0] win,
      input logic [1:0]                  r,
      input logic [1:0]                  c
   );
      logic [3:0] idx;
      idx = {1'b0, r, 1'b0} + {2'b00, r} + {2'b00, c};
      return win[idx];
   endfunction

   // Border replication: bottom variants repeat the last row, right ones the
   // last column, and the first column repeats itself on the left.
   assign lower = (kind_ff == VAR_LOWER) || (kind_ff == VAR_CORNER);
   assign right = (kind_ff == VAR_RIGHT) || (kind_ff == VAR_CORNER);

   always_comb begin
      rsel[0] = lower ? 2'd1 : 2'd0;
      rsel[1] = lower ? 2'd2 : 2'd1;
      rsel[2] = 2'd2;
      csel[0] = (right || job_ff.left_rep) ? 2'd1 : 2'd0;
      csel[1] = right ? 2'd2 : 2'd1;
      csel[2] = 2'd2;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            p[i*3 + j] = pick(job_ff.win, rsel[i], csel[j]);
         end
      end
   end

   // Sobel sums, then divide by four toward zero
   always_comb begin
      sum_xl = {2'b00, p[0]} + {1'b0, p[3], 1'b0} + {2'b00, p[6]};
      sum_xr = {2'b00, p[2]} + {1'b0, p[5], 1'b0} + {2'b00, p[8]};
      sum_yt = {2'b00, p[0]} + {1'b0, p[1], 1'b0} + {2'b00, p[2]};
      sum_yb = {2'b00, p[6]} + {1'b0, p[7], 1'b0} + {2'b00, p[8]};
      sx     = $signed({2'b00, sum_xr}) - $signed({2'b00, sum_xl});
      sy     = $signed({2'b00, sum_yb}) - $signed({2'b00, sum_yt});
      sx_adj = sx + (sx[SX_W-1] ? SX_W'(3) : SX_W'(0));
      sy_adj = sy + (sy[SX_W-1] ? SX_W'(3) : SX_W'(0));
      sx_q   = sx_adj >>> 2;
      sy_q   = sy_adj >>> 2;
      gx_in  = sx_q[SGS_GRAD_W-1:0];
      gy_in  = sy_q[SGS_GRAD_W-1:0];
   end

   // Squares feed the root unit directly
   assign gx_sq        = gx_ff * gx_ff;
   assign gy_sq        = gy_ff * gy_ff;
   assign sqrt_operand = gx_sq[SGS_SQ_W-1:0] + gy_sq[SGS_SQ_W-1:0];

   sgs_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sqrt_start),
      .operand (sqrt_operand),
      .busy    (sqrt_busy),
      .root    (sqrt_root)
   );

   // Which variant follows the current one within this job
   always_comb begin
      next_kind = VAR_CENTER;
      has_more  = 1'b0;
      unique case (kind_ff)
         VAR_CENTER: begin
            if (job_ff.last_col) begin
               next_kind = VAR_RIGHT;
               has_more  = 1'b1;
            end else if (job_ff.last_row) begin
               next_kind = VAR_LOWER;
               has_more  = 1'b1;
            end
         end
         VAR_RIGHT: begin
            if (job_ff.last_row) begin
               next_kind = VAR_LOWER;
               has_more  = 1'b1;
            end
         end
         VAR_LOWER: begin
            if (job_ff.last_col) begin
               next_kind = VAR_CORNER;
               has_more  = 1'b1;
            end
         end
         VAR_CORNER: begin
            has_more = 1'b0;
         end
         default: begin
            has_more = 1'b0;
         end
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Sequencer outputs
   always_comb begin
      job_pop    = 1'b0;
      sqrt_start = 1'b0;
      load_out   = 1'b0;
      unique case (state_ff)
         BK_IDLE:   job_pop    = !queue_status.empty;
         BK_GRAD:   job_pop    = 1'b0;
         BK_SQUARE: sqrt_start = 1'b1;
         BK_ROOT:   load_out   = !sqrt_busy && out_free;
         default:   job_pop    = 1'b0;
      endcase
   end

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!queue_status.empty) begin
               state_in = BK_GRAD;
            end
         end
         BK_GRAD:   state_in = BK_SQUARE;
         BK_SQUARE: state_in = BK_ROOT;
         BK_ROOT: begin
            if (load_out) begin
               state_in = has_more ? BK_GRAD : BK_IDLE;
            end
         end
         default:   state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      kind_in = kind_ff;
      if (job_pop) begin
         kind_in = VAR_CENTER;
      end else if (load_out && has_more) begin
         kind_in = next_kind;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         kind_ff      <= VAR_CENTER;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result position: upper variants sit one row up, left ones one column left
   assign out_row = lower ? job_ff.row : job_ff.row - SGS_COORD_W'(1);
   assign out_col = right ? job_ff.col : job_ff.col - SGS_COORD_W'(1);

   always_ff @(posedge clock) begin
      if (job_pop) begin
         job_ff <= job_data;
      end
      if (state_ff == BK_GRAD) begin
         gx_ff <= gx_in;
         gy_ff <= gy_in;
      end
      if (load_out) begin
         rsp_data_ff <= {{PAD_W{1'b0}}, out_col, out_row, sqrt_root, gy_ff, gx_ff};
         rsp_last_ff <= (kind_ff == VAR_CORNER);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_root_idle_on_start : assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_SQUARE) |-> !sqrt_busy)
      else $error("root unit started while busy");

   a_corner_only_at_end : assert property (@(posedge clock) disable iff (reset)
      load_out && (kind_ff == VAR_CORNER) |-> job_ff.last_col && job_ff.last_row)
      else $error("frame end result issued away from the frame corner");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for sobel_gradient_stream
// Streams grey pixels into the block and predicts every gradient word from
// its own copy of the line buffers, window and frame counters. It starts
// with the reset frame size, then runs clamped and oversized sizes,
// full-scale edges, spare register writes, abandoned frames and small random
// frames. Both stream sides idle at random, and every word that comes out
// is compared field by field in order.
// ----------------------------------------------------------------------------
module tb;
   import sgs_pkg::*;

   localparam int DUT_MAX_WIDTH  = 1024;
   localparam int WIDTH_LIMIT    = (DUT_MAX_WIDTH < SGS_DIM_MAX) ? DUT_MAX_WIDTH : SGS_DIM_MAX;
   localparam int SETTLE_CYCLES  = 64;
   localparam int DRAIN_LIMIT    = 4000;
   localparam int RESET_PIXELS   = 12;
   localparam int RANDOM_PIXELS  = 45;
   localparam int CYCLE_LIMIT    = 200000;

   // Register indexes with no register behind them
   localparam logic [SGS_CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [SGS_CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef enum int {
      PIX_UNIFORM,
      PIX_EXTREME,
      PIX_NEAR
   } pixel_mix_type;

   typedef struct {
      logic signed [SGS_GRAD_W-1:0] grad_x;
      logic signed [SGS_GRAD_W-1:0] grad_y;
      logic [SGS_MAG_W-1:0]         magnitude;
      logic [SGS_COORD_W-1:0]       out_row;
      logic [SGS_COORD_W-1:0]       out_col;
      logic                         frame_last;
   } gradient_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   // req_tdata: [7:0] pixel
   logic [SGS_REQ_DATA_W-1:0]         req_tdata = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   // rsp_tdata: [8:0] grad_x, [17:9] grad_y, [25:18] magnitude,
   //            [35:26] out_row, [45:36] out_col, [47:46] zero
   logic [SGS_RSP_DATA_W-1:0]         rsp_tdata;
   logic                              rsp_tlast;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [SGS_CSR_INDEX_W-1:0]        csr_index = '0;
   logic [SGS_DIM_W-1:0]              csr_data = '0;

   // Predicted state of the block
   logic [SGS_DIM_W-1:0]   frame_width_reg  = SGS_WIDTH_RESET;
   logic [SGS_DIM_W-1:0]   frame_height_reg = SGS_HEIGHT_RESET;
   logic [SGS_PIXEL_W-1:0] line_up1 [SGS_DIM_MAX];
   logic [SGS_PIXEL_W-1:0] line_up2 [SGS_DIM_MAX];
   logic [SGS_PIXEL_W-1:0] sobel_win [9] = '{default: '0};
   int                     col_pos = 0;
   int                     row_pos = 0;

   logic [SGS_PIXEL_W-1:0] pixel_queue [$];
   gradient_type           gradient_queue [$];

   int unsigned tx_idle_max = 0;
   int unsigned rx_idle_max = 0;
   int unsigned tx_wait = 0;
   int unsigned rx_wait = 0;
   int unsigned rx_draw;

   int fail_count    = 0;
   int pixels_sent   = 0;
   int words_checked = 0;
   int frames_done   = 0;
   int csr_writes    = 0;

   sobel_gradient_stream #(
      .MAX_WIDTH (DUT_MAX_WIDTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int clamp_dim(logic [SGS_DIM_W-1:0] v, int hi);
      if (v < SGS_DIM_MIN) return int'(SGS_DIM_MIN);
      if (int'(v) > hi) return hi;
      return int'(v);
   endfunction

   // Apply the Sobel masks to a window patch and queue the resulting word
   task automatic push_gradient(input int ra, rb, rc, cl, cm, cr,
                                input int row, col, input bit last);
      int           p [9];
      int           sel_r [3];
      int           sel_c [3];
      int           sx, sy, gx, gy, sq, root, i, j;
      gradient_type g;
      sel_r = '{ra, rb, rc};
      sel_c = '{cl, cm, cr};
      for (i = 0; i < 3; i++)
         for (j = 0; j < 3; j++)
            p[i*3+j] = int'(sobel_win[sel_r[i]*3 + sel_c[j]]);
      sx = (p[2] + 2*p[5] + p[8]) - (p[0] + 2*p[3] + p[6]);
      sy = (p[6] + 2*p[7] + p[8]) - (p[0] + 2*p[1] + p[2]);
      // integer division truncates toward zero
      gx = sx / 4;
      gy = sy / 4;
      sq = gx*gx + gy*gy;
      root = 0;
      while ((root + 1) * (root + 1) <= sq) root++;
      if (root > 255) root = 255;
      g.grad_x     = SGS_GRAD_W'(gx);
      g.grad_y     = SGS_GRAD_W'(gy);
      g.magnitude  = SGS_MAG_W'(root);
      g.out_row    = SGS_COORD_W'(row);
      g.out_col    = SGS_COORD_W'(col);
      g.frame_last = last;
      gradient_queue.push_back(g);
   endtask

   // Advance the predicted window by one pixel and queue what it releases
   task automatic sobel_step(input logic [SGS_PIXEL_W-1:0] px);
      int                     w, h, r, c, cl, i;
      logic [SGS_PIXEL_W-1:0] top, mid;
      bit                     last_col, last_row;
      w = clamp_dim(frame_width_reg, WIDTH_LIMIT);
      h = clamp_dim(frame_height_reg, SGS_DIM_MAX);
      r = row_pos;
      c = col_pos;
      if (c >= w) c = w - 1;
      if (r >= h) r = h - 1;
      last_col = (c == w - 1);
      last_row = (r == h - 1);
      // replicate the top border
      if (r == 0) begin
         top = px;
         mid = px;
      end else begin
         mid = line_up1[c];
         top = (r == 1) ? mid : line_up2[c];
      end
      for (i = 0; i < 3; i++) begin
         sobel_win[i*3]   = sobel_win[i*3+1];
         sobel_win[i*3+1] = sobel_win[i*3+2];
      end
      sobel_win[2] = top;
      sobel_win[5] = mid;
      sobel_win[8] = px;
      line_up2[c] = line_up1[c];
      line_up1[c] = px;
      if (r >= 1 && c >= 1) begin
         cl = (c == 1) ? 1 : 0;
         push_gradient(0, 1, 2, cl, 1, 2, r - 1, c - 1, 1'b0);
         if (last_col) push_gradient(0, 1, 2, 1, 2, 2, r - 1, c, 1'b0);
         // bottom row follows the row above it
         if (last_row) begin
            push_gradient(1, 2, 2, cl, 1, 2, r, c - 1, 1'b0);
            if (last_col) push_gradient(1, 2, 2, 1, 2, 2, r, c, 1'b1);
         end
      end
      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
         row_pos = r;
      end
   endtask

   task automatic apply_config(input logic [SGS_CSR_INDEX_W-1:0] index,
                               input logic [SGS_DIM_W-1:0] value);
      case (index)
         SGS_CSR_FRAME_WIDTH: begin
            frame_width_reg = value;
            col_pos = 0;
            row_pos = 0;
         end
         SGS_CSR_FRAME_HEIGHT: begin
            frame_height_reg = value;
            col_pos = 0;
            row_pos = 0;
         end
         default: ;
      endcase
   endtask

   task automatic compare_field(input string name, input int want_v, input int got_v);
      if (want_v != got_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
         fail_count++;
      end
   endtask

   task automatic check_gradient(input logic [SGS_RSP_DATA_W-1:0] word, input logic last);
      gradient_type want;
      if (gradient_queue.size() == 0) begin
         $error("Unexpected gradient word at row %0d col %0d", word[35:26], word[45:36]);
         fail_count++;
      end else begin
         want = gradient_queue.pop_front();
         compare_field("grad_x", int'(want.grad_x), int'($signed(word[8:0])));
         compare_field("grad_y", int'(want.grad_y), int'($signed(word[17:9])));
         compare_field("magnitude", int'(want.magnitude), int'(word[25:18]));
         compare_field("out_row", int'(want.out_row), int'(word[35:26]));
         compare_field("out_col", int'(want.out_col), int'(word[45:36]));
         compare_field("frame_last", int'(want.frame_last), int'(last));
      end
   endtask

   function automatic logic [SGS_PIXEL_W-1:0] random_pixel(pixel_mix_type mix,
                                                          logic [SGS_PIXEL_W-1:0] base);
      case (mix)
         PIX_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         PIX_NEAR:    return base ^ 8'($urandom_range(0, 7));
         default:     return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic queue_pixels(input int n, input pixel_mix_type mix);
      logic [SGS_PIXEL_W-1:0] base;
      int                     k;
      base = SGS_PIXEL_W'($urandom_range(0, 255));
      for (k = 0; k < n; k++) pixel_queue.push_back(random_pixel(mix, base));
   endtask

   // Hold off until every pixel is taken and every expected word has come
   task automatic drain_stream();
      int waited;
      while (pixel_queue.size() != 0 || req_tvalid) @(posedge clock);
      waited = 0;
      while (gradient_queue.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (gradient_queue.size() != 0) begin
         $error("%0d expected gradient words never came", gradient_queue.size());
         fail_count++;
         gradient_queue.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [SGS_CSR_INDEX_W-1:0] index,
                            input logic [SGS_DIM_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_config(index, value);
      csr_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Pixel driver: one word per draw, random gap before the next
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         tx_wait    <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            sobel_step(req_tdata[SGS_PIXEL_W-1:0]);
            pixels_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (tx_wait > 0) begin
               req_tvalid <= 1'b0;
               tx_wait    <= tx_wait - 1;
            end else if (pixel_queue.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pixel_queue.pop_front();
               tx_wait    <= $urandom_range(0, tx_idle_max);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: check each word, then stall a random number of cycles
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_wait    <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         check_gradient(rsp_tdata, rsp_tlast);
         words_checked++;
         if (rsp_tlast) frames_done++;
         rx_draw = $urandom_range(0, rx_idle_max);
         if (rx_draw == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            rx_wait    <= rx_draw;
         end
      end else if (!rsp_tready) begin
         if (rx_wait <= 1) begin
            rsp_tready <= 1'b1;
            rx_wait    <= 0;
         end else begin
            rx_wait <= rx_wait - 1;
         end
      end
   end

   // Give up if the run hangs
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      int                     fw, fh, total, count, pause_at, k, r, c, random_pixels;
      pixel_mix_type          mix;
      logic [SGS_PIXEL_W-1:0] level;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset frame size: part of the first row, which releases nothing
      tx_idle_max = 6;
      rx_idle_max = 6;
      queue_pixels(RESET_PIXELS, PIX_UNIFORM);
      drain_stream();

      // Sizes below the minimum clamp to a 2x2 frame
      csr_write(SGS_CSR_FRAME_WIDTH, 11'd0);
      csr_write(SGS_CSR_FRAME_HEIGHT, 11'd1);
      queue_pixels(4, PIX_EXTREME);
      drain_stream();
      csr_write(SGS_CSR_FRAME_HEIGHT, 11'd0);
      csr_write(SGS_CSR_FRAME_WIDTH, 11'd1);
      queue_pixels(4, PIX_UNIFORM);
      drain_stream();

      // Quadrant edge on a 4x3 frame, then its inverse: full-scale and saturated
      tx_idle_max = 0;
      csr_write(SGS_CSR_FRAME_WIDTH, 11'd4);
      csr_write(SGS_CSR_FRAME_HEIGHT, 11'd3);
      for (k = 0; k < 24; k++) begin
         r = (k % 12) / 4;
         c = k % 4;
         level = (r >= 2 || c >= 2) ? 8'hFF : 8'h00;
         pixel_queue.push_back(k < 12 ? level : ~level);
      end
      drain_stream();

      // Spare register indexes leave the frame position alone
      tx_idle_max = 6;
      csr_write(SGS_CSR_FRAME_WIDTH, 11'd5);
      queue_pixels(7, PIX_UNIFORM);
      drain_stream();
      csr_write(CSR_SPARE_A, 11'($urandom_range(0, 2047)));
      csr_write(CSR_SPARE_B, 11'h7FF);
      queue_pixels(8, PIX_NEAR);
      drain_stream();

      // Abandon a frame partway; the height write restarts at row 0
      queue_pixels(9, PIX_UNIFORM);
      drain_stream();
      csr_write(SGS_CSR_FRAME_HEIGHT, 11'd4);
      queue_pixels(20, PIX_UNIFORM);
      drain_stream();

      // Oversized height clamps to the largest frame: no last row is reached
      rx_idle_max = 0;
      csr_write(SGS_CSR_FRAME_WIDTH, SGS_DIM_MIN);
      csr_write(SGS_CSR_FRAME_HEIGHT, 11'h7FF);
      queue_pixels(10, PIX_EXTREME);
      drain_stream();

      // Random frames: mostly whole frames, some cut short or run back to back
      random_pixels = 0;
      while (random_pixels < RANDOM_PIXELS) begin
         if ($urandom_range(0, 4) == 0) begin
            fw = $urandom_range(7, 12);
            fh = int'(SGS_DIM_MIN);
         end else begin
            fw = $urandom_range(2, 6);
            fh = $urandom_range(2, 4);
         end
         tx_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
         rx_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
         if ($urandom_range(0, 1)) begin
            csr_write(SGS_CSR_FRAME_WIDTH, SGS_DIM_W'(fw));
            csr_write(SGS_CSR_FRAME_HEIGHT, SGS_DIM_W'(fh));
         end else begin
            csr_write(SGS_CSR_FRAME_HEIGHT, SGS_DIM_W'(fh));
            csr_write(SGS_CSR_FRAME_WIDTH, SGS_DIM_W'(fw));
         end
         total = fw * fh;
         case ($urandom_range(0, 5))
            0:       count = $urandom_range(1, total - 1);
            1:       count = 2 * total;
            default: count = total;
         endcase
         mix = pixel_mix_type'($urandom_range(0, 2));
         // Now and then stop the sender mid-frame until all words are back
         if (count > 1 && $urandom_range(0, 3) == 0) begin
            pause_at = $urandom_range(1, count - 1);
            queue_pixels(pause_at, mix);
            drain_stream();
            queue_pixels(count - pause_at, mix);
         end else begin
            queue_pixels(count, mix);
         end
         drain_stream();
         random_pixels += count;
      end

      $display("Run covered %0d pixels, %0d gradient words and %0d complete frames",
               pixels_sent, words_checked, frames_done);
      $display("%0d register writes; small frames, clamped and oversized sizes, spare indexes",
               csr_writes);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/sgs_pkg.sv
hw/rtl/sgs_sqrt.sv
hw/rtl/sgs_queue.sv
hw/rtl/sgs_front.sv
hw/rtl/sgs_back.sv
hw/rtl/sobel_gradient_stream.sv
verif/tb.sv
